FILE: rtl/wmr_pkg.sv
// Shared types and constants for the windowed median rate estimator.
// No dependencies; compile first.
`default_nettype none
package wmr_pkg;

   localparam int HISTORY_LIMIT = 1024;
   localparam int STORE_DEPTH   = 2048;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int CNT_W         = 12;
   localparam int SUM_W         = 43;
   localparam int KEEP_COUNT    = HISTORY_LIMIT * 3 / 4;
   localparam int CSR_ADDR_W    = 3;

   localparam logic REG_MIN_SAMPLES = 1'b0;
   localparam logic REG_SAFETY_MULT = 1'b1;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_BLOCK = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STATS,
      ST_SELECT,
      ST_DIV,
      ST_MUL,
      ST_TOT
   } state_type;

   typedef struct packed {
      logic [11:0] stored_count;
      logic        overflowed;
      logic        stats_valid;
      logic        estimate_valid;
      logic [11:0] match_count;
      logic [31:0] min_rate;
      logic [31:0] max_rate;
      logic [31:0] median_rate;
      logic [31:0] mean_rate;
      logic [39:0] estimated_rate;
      logic [59:0] estimated_total;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/wmr_if.sv
// Valid/ready channel interfaces for request and response transfers.
// Depends on nothing beyond the language.
`default_nettype none
interface wmr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] rate_value;
   logic [15:0] wait_count;
   logic [15:0] target_wait;
   logic [19:0] item_size;
   modport source (output valid, action, rate_value, wait_count, target_wait, item_size,
                   input ready);
   modport sink   (input valid, action, rate_value, wait_count, target_wait, item_size,
                   output ready);
endinterface

interface wmr_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] stored_count;
   logic        overflowed;
   logic        stats_valid;
   logic        estimate_valid;
   logic [11:0] match_count;
   logic [31:0] min_rate;
   logic [31:0] max_rate;
   logic [31:0] median_rate;
   logic [31:0] mean_rate;
   logic [39:0] estimated_rate;
   logic [59:0] estimated_total;
   modport source (output valid, stored_count, overflowed, stats_valid, estimate_valid,
                   match_count, min_rate, max_rate, median_rate, mean_rate,
                   estimated_rate, estimated_total, input ready);
   modport sink   (input valid, stored_count, overflowed, stats_valid, estimate_valid,
                   match_count, min_rate, max_rate, median_rate, mean_rate,
                   estimated_rate, estimated_total, output ready);
endinterface
`default_nettype wire

FILE: rtl/windowed_median_rate_estimator_core.sv
// Top level of the windowed median rate estimator: record ring memory,
// scan engine, radix selection, divider and scaling multipliers.
// Depends on wmr_pkg and wmr_if.
//
// Usage: requests arrive on req_if (valid/ready), one response per request
// leaves on rsp_if. Add, block-done, clear and short queries (fewer records
// than min_samples) complete in the accepting cycle; the response is
// registered and visible in the next cycle, so these sustain one transfer
// per cycle while the receiver keeps rsp_if ready.
// A full query scans the ring memory once for count/min/max/sum of records
// whose wait is within target_wait, then runs 32 radix-select passes per
// median element (one or two elements), 43 divider steps, a multiply state
// and a total state; each pass rereads the memory through its one read port.
// Reset clears the ring pointers and restores register defaults; no memory
// sweep is needed. While a response waits on a stalled receiver, no new
// request is taken unless the response is transferred in the same cycle.
// CSR: min_samples at 0x0, safety_multiplier_q8 at 0x4.
`default_nettype none
module windowed_median_rate_estimator_core (
   input  wire                               clock,
   input  wire                               reset,
   wmr_req_if.sink                           req_if,
   wmr_rsp_if.source                         rsp_if,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire [wmr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire [31:0]                        csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam logic [wmr_pkg::CNT_W-1:0] DEPTH_C = wmr_pkg::CNT_W'(wmr_pkg::STORE_DEPTH);
   localparam logic [wmr_pkg::CNT_W-1:0] LIMIT_C = wmr_pkg::CNT_W'(wmr_pkg::HISTORY_LIMIT);
   localparam logic [wmr_pkg::CNT_W-1:0] KEEP_C  = wmr_pkg::CNT_W'(wmr_pkg::KEEP_COUNT);

   wmr_pkg::state_type state_ff, state_in;

   logic [wmr_pkg::ADDR_W-1:0] oldest_ff, oldest_in;
   logic [wmr_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [11:0]                min_samples_ff;
   logic [15:0]                mult_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   wmr_pkg::rsp_type           rsp_ff, rsp_in;

   logic [47:0] mem [wmr_pkg::STORE_DEPTH];
   logic [47:0] mem_q_ff;
   logic        mem_we;
   logic [wmr_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;

   logic [15:0]               target_ff;
   logic [19:0]               size_ff;
   logic [wmr_pkg::CNT_W-1:0] iss_ff;
   logic                      pend_ff;
   logic [wmr_pkg::CNT_W-1:0] n_ff, c_ff, k_ff;
   logic [31:0]               min_ff, max_ff, pfx_ff, sel0_ff, med_ff;
   logic [wmr_pkg::SUM_W-1:0] sum_ff, quo_ff;
   logic [4:0]                bit_ff;
   logic                      second_ff;
   logic [11:0]               rem_ff;
   logic [5:0]                step_ff;
   logic [39:0]               est_ff;

   logic        accept, rd_en, pass_done, match, even, take_one, csr_wr, is_query_long;
   logic [31:0] rate_q, hi_mask, pfx_nx;
   logic [15:0] wait_q;
   logic [wmr_pkg::CNT_W-1:0] k_nx;
   logic [12:0] rem_sh;
   logic        div_ge;
   logic [32:0] med_sum;
   logic [47:0] est_prod;
   logic [59:0] tot_prod;

   assign accept    = req_if.valid && req_if.ready;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rate_q    = mem_q_ff[47:16];
   assign wait_q    = mem_q_ff[15:0];
   assign match     = wait_q <= target_ff;
   assign pass_done = (iss_ff == count_ff) && !pend_ff;
   assign even      = !n_ff[0];
   assign hi_mask   = (32'hFFFF_FFFF << bit_ff) << 1;
   assign take_one  = k_ff >= c_ff;
   assign pfx_nx    = pfx_ff | (take_one ? (32'h1 << bit_ff) : 32'h0);
   assign k_nx      = take_one ? k_ff - c_ff : k_ff;
   assign rem_sh    = {rem_ff, quo_ff[wmr_pkg::SUM_W-1]};
   assign div_ge    = rem_sh >= {1'b0, n_ff};
   assign med_sum   = {1'b0, sel0_ff} + {1'b0, pfx_nx};
   assign est_prod  = med_ff * mult_ff;
   assign tot_prod  = est_ff * size_ff;
   assign is_query_long = wmr_pkg::action_type'(req_if.action) == wmr_pkg::ACT_QUERY
                          && count_ff >= min_samples_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wmr_pkg::ST_IDLE: begin
            if (accept && is_query_long) state_in = wmr_pkg::ST_STATS;
         end
         wmr_pkg::ST_STATS: begin
            if (pass_done) state_in = (n_ff == '0) ? wmr_pkg::ST_TOT : wmr_pkg::ST_SELECT;
         end
         wmr_pkg::ST_SELECT: begin
            if (pass_done && bit_ff == 5'd0 && !(even && !second_ff))
               state_in = wmr_pkg::ST_DIV;
         end
         wmr_pkg::ST_DIV: begin
            if (step_ff == 6'(wmr_pkg::SUM_W - 1)) state_in = wmr_pkg::ST_MUL;
         end
         wmr_pkg::ST_MUL: state_in = wmr_pkg::ST_TOT;
         wmr_pkg::ST_TOT: state_in = wmr_pkg::ST_IDLE;
         default:         state_in = wmr_pkg::ST_IDLE;
      endcase
   end

   // outputs and ring control
   always_comb begin
      req_if.ready = (state_ff == wmr_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
      rd_en        = (state_ff == wmr_pkg::ST_STATS || state_ff == wmr_pkg::ST_SELECT)
                     && iss_ff != count_ff;
      mem_raddr    = oldest_ff + iss_ff[wmr_pkg::ADDR_W-1:0];
      mem_we       = 1'b0;
      mem_waddr    = oldest_ff + count_ff[wmr_pkg::ADDR_W-1:0];
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_in = '0;
         unique case (wmr_pkg::action_type'(req_if.action))
            wmr_pkg::ACT_ADD: begin
               mem_we = 1'b1;
               if (count_ff >= DEPTH_C) begin
                  mem_waddr         = oldest_ff;
                  oldest_in         = oldest_ff + 1'b1;
                  rsp_in.overflowed = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            wmr_pkg::ACT_BLOCK: begin
               if (count_ff > LIMIT_C) begin
                  oldest_in = oldest_ff + wmr_pkg::ADDR_W'(count_ff - KEEP_C);
                  count_in  = KEEP_C;
               end
            end
            wmr_pkg::ACT_CLEAR: begin
               oldest_in = '0;
               count_in  = '0;
            end
            wmr_pkg::ACT_QUERY: ;
            default: ;
         endcase
         rsp_in.stored_count = count_in;
         rsp_valid_in        = !is_query_long;
      end
      if (state_ff == wmr_pkg::ST_TOT) begin
         rsp_in                = '0;
         rsp_in.stored_count   = count_ff;
         rsp_in.stats_valid    = 1'b1;
         rsp_in.match_count    = n_ff;
         if (n_ff != '0) begin
            rsp_in.estimate_valid  = 1'b1;
            rsp_in.min_rate        = min_ff;
            rsp_in.max_rate        = max_ff;
            rsp_in.median_rate     = med_ff;
            rsp_in.mean_rate       = quo_ff[31:0];
            rsp_in.estimated_rate  = est_ff;
            rsp_in.estimated_total = tot_prod;
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= wmr_pkg::ST_IDLE;
         oldest_ff      <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         min_samples_ff <= 12'd10;
         mult_ff        <= 16'd256;
         pend_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= rd_en;
         if (csr_wr) begin
            unique case (csr_paddr[2])
               wmr_pkg::REG_MIN_SAMPLES: min_samples_ff <= csr_pwdata[11:0];
               wmr_pkg::REG_SAFETY_MULT: mult_ff        <= csr_pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= {req_if.rate_value, req_if.wait_count};
      mem_q_ff <= mem[mem_raddr];
   end

   // query datapath
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (rd_en) iss_ff <= iss_ff + 1'b1;
      unique case (state_ff)
         wmr_pkg::ST_IDLE: begin
            target_ff <= req_if.target_wait;
            size_ff   <= req_if.item_size;
            iss_ff    <= '0;
            n_ff      <= '0;
            min_ff    <= '1;
            max_ff    <= '0;
            sum_ff    <= '0;
         end
         wmr_pkg::ST_STATS: begin
            if (pend_ff && match) begin
               n_ff   <= n_ff + 1'b1;
               sum_ff <= sum_ff + wmr_pkg::SUM_W'(rate_q);
               if (rate_q < min_ff) min_ff <= rate_q;
               if (rate_q > max_ff) max_ff <= rate_q;
            end
            if (pass_done) begin
               iss_ff    <= '0;
               c_ff      <= '0;
               pfx_ff    <= '0;
               bit_ff    <= 5'd31;
               second_ff <= 1'b0;
               k_ff      <= (n_ff - 1'b1) >> 1;
               est_ff    <= '0;
            end
         end
         wmr_pkg::ST_SELECT: begin
            if (pend_ff && match && ((rate_q ^ pfx_ff) & hi_mask) == '0 && !rate_q[bit_ff])
               c_ff <= c_ff + 1'b1;
            if (pass_done) begin
               iss_ff <= '0;
               c_ff   <= '0;
               if (bit_ff != 5'd0) begin
                  pfx_ff <= pfx_nx;
                  k_ff   <= k_nx;
                  bit_ff <= bit_ff - 1'b1;
               end else if (even && !second_ff) begin
                  sel0_ff   <= pfx_nx;
                  second_ff <= 1'b1;
                  pfx_ff    <= '0;
                  bit_ff    <= 5'd31;
                  k_ff      <= n_ff >> 1;
               end else begin
                  med_ff  <= even ? med_sum[32:1] : pfx_nx;
                  rem_ff  <= '0;
                  quo_ff  <= sum_ff;
                  step_ff <= '0;
               end
            end
         end
         wmr_pkg::ST_DIV: begin
            rem_ff  <= div_ge ? 12'(rem_sh - {1'b0, n_ff}) : rem_sh[11:0];
            quo_ff  <= {quo_ff[wmr_pkg::SUM_W-2:0], div_ge};
            step_ff <= step_ff + 1'b1;
         end
         wmr_pkg::ST_MUL: est_ff <= est_prod[47:8];
         wmr_pkg::ST_TOT: ;
         default: ;
      endcase
   end

   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[2])
         wmr_pkg::REG_MIN_SAMPLES: csr_prdata = {20'd0, min_samples_ff};
         wmr_pkg::REG_SAFETY_MULT: csr_prdata = {16'd0, mult_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.stored_count    = rsp_ff.stored_count;
   assign rsp_if.overflowed      = rsp_ff.overflowed;
   assign rsp_if.stats_valid     = rsp_ff.stats_valid;
   assign rsp_if.estimate_valid  = rsp_ff.estimate_valid;
   assign rsp_if.match_count     = rsp_ff.match_count;
   assign rsp_if.min_rate        = rsp_ff.min_rate;
   assign rsp_if.max_rate        = rsp_ff.max_rate;
   assign rsp_if.median_rate     = rsp_ff.median_rate;
   assign rsp_if.mean_rate       = rsp_ff.mean_rate;
   assign rsp_if.estimated_rate  = rsp_ff.estimated_rate;
   assign rsp_if.estimated_total = rsp_ff.estimated_total;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C) else $error("record count above depth");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> state_ff == wmr_pkg::ST_IDLE) else $error("ready while busy");
   a_est_stats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.estimate_valid |-> rsp_ff.stats_valid)
      else $error("estimate without stats");
   a_median_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.estimate_valid |->
         rsp_ff.min_rate <= rsp_ff.median_rate && rsp_ff.median_rate <= rsp_ff.max_rate)
      else $error("median outside min/max");

endmodule
`default_nettype wire
